// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Each macro expects aclk in the scope where it is used; CHK_RUN also expects aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define CHK_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that also covers reset cycles
`define CHK_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/cpuex_pkg.sv =====
// Shared constants for the opcode block 0 execute core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpuex_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    // flag bit positions
    localparam int FL_Z = 3;
    localparam int FL_N = 2;
    localparam int FL_H = 1;
    localparam int FL_C = 0;

    // opcodes handled as special cases
    localparam logic [5:0] OP_NOP   = 6'h00;
    localparam logic [5:0] OP_LDNSP = 6'h08;
    localparam logic [5:0] OP_STOP  = 6'h10;
    localparam logic [5:0] OP_JR    = 6'h18;
    localparam logic [5:0] OP_JRNZ  = 6'h20;
    localparam logic [5:0] OP_JRZ   = 6'h28;
    localparam logic [5:0] OP_JRNC  = 6'h30;
    localparam logic [5:0] OP_JRC   = 6'h38;
    localparam logic [5:0] OP_RLCA  = 6'h07;
    localparam logic [5:0] OP_RRCA  = 6'h0F;
    localparam logic [5:0] OP_RLA   = 6'h17;
    localparam logic [5:0] OP_RRA   = 6'h1F;
    localparam logic [5:0] OP_DAA   = 6'h27;
    localparam logic [5:0] OP_CPL   = 6'h2F;
    localparam logic [5:0] OP_SCF   = 6'h37;

    // low three opcode bits
    localparam logic [2:0] LO_INC = 3'd4;
    localparam logic [2:0] LO_DEC = 3'd5;
    localparam logic [2:0] LO_LDN = 3'd6;
    localparam logic [2:0] LO_JR  = 3'd0;

    // low nibble groups
    localparam logic [3:0] NB_LDRR = 4'h1;
    localparam logic [3:0] NB_STA  = 4'h2;
    localparam logic [3:0] NB_INCR = 4'h3;
    localparam logic [3:0] NB_ADDH = 4'h9;
    localparam logic [3:0] NB_LDA  = 4'hA;
    localparam logic [3:0] NB_DECR = 4'hB;

    // 8-bit operand codes
    localparam logic [2:0] R8_B  = 3'd0;
    localparam logic [2:0] R8_C  = 3'd1;
    localparam logic [2:0] R8_D  = 3'd2;
    localparam logic [2:0] R8_E  = 3'd3;
    localparam logic [2:0] R8_H  = 3'd4;
    localparam logic [2:0] R8_L  = 3'd5;
    localparam logic [2:0] R8_HL = 3'd6;
    localparam logic [2:0] R8_A  = 3'd7;

    // 16-bit pair codes
    localparam logic [1:0] RP_BC = 2'd0;
    localparam logic [1:0] RP_DE = 2'd1;
    localparam logic [1:0] RP_HL = 2'd2;
    localparam logic [1:0] RP_SP = 2'd3;

    localparam logic [4:0] CYC_4  = 5'd4;
    localparam logic [4:0] CYC_8  = 5'd8;
    localparam logic [4:0] CYC_12 = 5'd12;
    localparam logic [4:0] CYC_20 = 5'd20;

endpackage

`default_nettype wire

// ===== rtl/cpu_opcode_block0_execute_core.sv =====
// Execute core for CPU opcodes 0x00-0x3F with register file and byte memory.
// Depends on cpuex_pkg, cpuex_ram and assert_macros.svh.
//
// Usage:
//   Input channel s_*: one instruction per transfer (opcode, two immediates).
//   Result channel m_*: one transfer per instruction with all registers,
//   the stop flag and the T-cycle count after execution.
//   In the accept cycle the byte memory is read (or the low byte of
//   LD (nn),SP written); then, in the ST_EXEC state, the registers are
//   updated, the memory written back, the result loaded and m_valid
//   raised. Because of the single memory port, a new instruction is not
//   accepted while one is in ST_EXEC.
//   A waiting result does not block the next input transfer when m_ready is
//   high in the same cycle; while the receiver stalls, s_ready stays low.
//   Reset (aresetn low, synchronous) clears the CPU registers, the stop flag
//   and the result valid, but not the T-cycle count. Memory contents are
//   undefined until written; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpu_opcode_block0_execute_core #(
    parameter int MEM_ADDR_BITS = cpuex_pkg::MEM_ADDR_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [5:0]  s_opcode,
    input  wire logic [7:0]  s_imm_first,
    input  wire logic [7:0]  s_imm_second,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_acc_out,
    output logic [3:0]       m_flags_out,
    output logic [15:0]      m_bc_out,
    output logic [15:0]      m_de_out,
    output logic [15:0]      m_hl_out,
    output logic [15:0]      m_sp_out,
    output logic [15:0]      m_pc_out,
    output logic             m_stopped_out,
    output logic [4:0]       m_cycles_out
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t      state_reg;
    logic        m_valid_reg;
    logic [7:0]  acc_reg,  acc_next;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] bc_reg, bc_next, de_reg, de_next, hl_reg, hl_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic        stopped_reg, stopped_next;
    logic [4:0]  cyc_reg, cyc_next;
    logic [5:0]  op_reg;
    logic [7:0]  n1_reg, n2_reg;

    logic                     mem_en, mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0]               mem_wdata, mem_rdata;

    logic                     ex_we;
    logic [MEM_ADDR_BITS-1:0] ex_addr;
    logic [7:0]               ex_wdata;

    logic s_xfer;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;

    // accept-cycle memory access, and the write-back in ST_EXEC
    logic [15:0] acc_addr16;
    logic [15:0] nn_in;
    always_comb begin
        nn_in = {s_imm_first, s_imm_second};
        case (s_opcode[5:4])
            cpuex_pkg::RP_BC: acc_addr16 = bc_reg;
            cpuex_pkg::RP_DE: acc_addr16 = de_reg;
            default:          acc_addr16 = hl_reg;
        endcase
        if (s_opcode[2:0] == cpuex_pkg::LO_INC || s_opcode[2:0] == cpuex_pkg::LO_DEC) begin
            acc_addr16 = hl_reg;
        end
        if (state_reg == ST_EXEC) begin
            mem_en    = ex_we;
            mem_we    = 1'b1;
            mem_addr  = ex_addr;
            mem_wdata = ex_wdata;
        end else if (s_opcode == cpuex_pkg::OP_LDNSP) begin
            mem_en    = s_xfer;
            mem_we    = 1'b1;
            mem_addr  = nn_in[MEM_ADDR_BITS-1:0];
            mem_wdata = sp_reg[7:0];
        end else begin
            mem_en    = s_xfer;
            mem_we    = 1'b0;
            mem_addr  = acc_addr16[MEM_ADDR_BITS-1:0];
            mem_wdata = acc_reg;
        end
    end

    cpuex_ram #(
        .WIDTH (8),
        .DEPTH (2 ** MEM_ADDR_BITS)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // execute
    logic [2:0]  lo, rsel;
    logic [1:0]  pr;
    logic [3:0]  nib;
    logic [15:0] nn, off, pval, paddr, hl_sum16;
    logic [7:0]  v8, r8;
    logic [16:0] hsum;
    logic [12:0] hsum12;
    logic [8:0]  daa_t;
    logic [7:0]  daa_s;
    logic        take;

    always_comb begin
        lo   = op_reg[2:0];
        rsel = op_reg[5:3];
        pr   = op_reg[5:4];
        nib  = op_reg[3:0];
        nn   = {n1_reg, n2_reg};
        off  = {{8{n1_reg[7]}}, n1_reg};

        acc_next     = acc_reg;
        flags_next   = flags_reg;
        bc_next      = bc_reg;
        de_next      = de_reg;
        hl_next      = hl_reg;
        sp_next      = sp_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        cyc_next     = cpuex_pkg::CYC_4;
        ex_we        = 1'b0;
        ex_addr      = hl_reg[MEM_ADDR_BITS-1:0];
        ex_wdata     = n1_reg;
        take         = 1'b1;
        r8           = 8'd0;
        daa_t        = 9'd0;
        daa_s        = 8'd0;

        case (rsel)
            cpuex_pkg::R8_B:  v8 = bc_reg[15:8];
            cpuex_pkg::R8_C:  v8 = bc_reg[7:0];
            cpuex_pkg::R8_D:  v8 = de_reg[15:8];
            cpuex_pkg::R8_E:  v8 = de_reg[7:0];
            cpuex_pkg::R8_H:  v8 = hl_reg[15:8];
            cpuex_pkg::R8_L:  v8 = hl_reg[7:0];
            cpuex_pkg::R8_HL: v8 = mem_rdata;
            default:          v8 = acc_reg;
        endcase

        case (pr)
            cpuex_pkg::RP_BC: pval = bc_reg;
            cpuex_pkg::RP_DE: pval = de_reg;
            cpuex_pkg::RP_HL: pval = hl_reg;
            default:          pval = sp_reg;
        endcase

        case (pr)
            cpuex_pkg::RP_BC: paddr = bc_reg;
            cpuex_pkg::RP_DE: paddr = de_reg;
            default:          paddr = hl_reg;
        endcase

        hsum     = {1'b0, hl_reg} + {1'b0, pval};
        hsum12   = {1'b0, hl_reg[11:0]} + {1'b0, pval[11:0]};
        hl_sum16 = hsum[15:0];

        if (lo == cpuex_pkg::LO_INC || lo == cpuex_pkg::LO_DEC || lo == cpuex_pkg::LO_LDN) begin
            if (lo == cpuex_pkg::LO_INC) begin
                r8 = v8 + 8'd1;
                flags_next[cpuex_pkg::FL_H] = (v8[3:0] == 4'hF);
                flags_next[cpuex_pkg::FL_N] = 1'b0;
                flags_next[cpuex_pkg::FL_Z] = (r8 == 8'd0);
                cyc_next = (rsel == cpuex_pkg::R8_HL) ? cpuex_pkg::CYC_12 : cpuex_pkg::CYC_4;
            end else if (lo == cpuex_pkg::LO_DEC) begin
                r8 = v8 - 8'd1;
                flags_next[cpuex_pkg::FL_H] = (v8[3:0] == 4'h0);
                flags_next[cpuex_pkg::FL_N] = 1'b1;
                flags_next[cpuex_pkg::FL_Z] = (r8 == 8'd0);
                cyc_next = (rsel == cpuex_pkg::R8_HL) ? cpuex_pkg::CYC_12 : cpuex_pkg::CYC_4;
            end else begin
                r8 = n1_reg;
                cyc_next = (rsel == cpuex_pkg::R8_HL) ? cpuex_pkg::CYC_12 : cpuex_pkg::CYC_8;
            end
            case (rsel)
                cpuex_pkg::R8_B:  bc_next[15:8] = r8;
                cpuex_pkg::R8_C:  bc_next[7:0]  = r8;
                cpuex_pkg::R8_D:  de_next[15:8] = r8;
                cpuex_pkg::R8_E:  de_next[7:0]  = r8;
                cpuex_pkg::R8_H:  hl_next[15:8] = r8;
                cpuex_pkg::R8_L:  hl_next[7:0]  = r8;
                cpuex_pkg::R8_HL: begin
                    ex_we    = 1'b1;
                    ex_wdata = r8;
                end
                default:          acc_next = r8;
            endcase
        end else if (op_reg == cpuex_pkg::OP_LDNSP) begin
            ex_we    = 1'b1;
            ex_addr  = nn[MEM_ADDR_BITS-1:0] + {{(MEM_ADDR_BITS-1){1'b0}}, 1'b1};
            ex_wdata = sp_reg[15:8];
            cyc_next = cpuex_pkg::CYC_20;
        end else if (op_reg == cpuex_pkg::OP_STOP) begin
            stopped_next = 1'b1;
        end else if (lo == cpuex_pkg::LO_JR && op_reg >= cpuex_pkg::OP_JR) begin
            case (op_reg)
                cpuex_pkg::OP_JRNZ: take = !flags_reg[cpuex_pkg::FL_Z];
                cpuex_pkg::OP_JRZ:  take = flags_reg[cpuex_pkg::FL_Z];
                cpuex_pkg::OP_JRNC: take = !flags_reg[cpuex_pkg::FL_C];
                cpuex_pkg::OP_JRC:  take = flags_reg[cpuex_pkg::FL_C];
                default:            take = 1'b1;
            endcase
            if (take) begin
                pc_next = pc_reg + off;
            end
            cyc_next = take ? cpuex_pkg::CYC_12 : cpuex_pkg::CYC_8;
        end else if (op_reg == cpuex_pkg::OP_NOP) begin
            cyc_next = cpuex_pkg::CYC_4;
        end else if (nib == cpuex_pkg::NB_LDRR || nib == cpuex_pkg::NB_INCR
                     || nib == cpuex_pkg::NB_DECR) begin
            if (nib == cpuex_pkg::NB_LDRR) begin
                pval = nn;
                cyc_next = cpuex_pkg::CYC_12;
            end else if (nib == cpuex_pkg::NB_INCR) begin
                pval = pval + 16'd1;
                cyc_next = cpuex_pkg::CYC_8;
            end else begin
                pval = pval - 16'd1;
                cyc_next = cpuex_pkg::CYC_8;
            end
            case (pr)
                cpuex_pkg::RP_BC: bc_next = pval;
                cpuex_pkg::RP_DE: de_next = pval;
                cpuex_pkg::RP_HL: hl_next = pval;
                default:          sp_next = pval;
            endcase
        end else if (nib == cpuex_pkg::NB_ADDH) begin
            hl_next = hl_sum16;
            flags_next[cpuex_pkg::FL_H] = hsum12[12];
            flags_next[cpuex_pkg::FL_C] = hsum[16];
            flags_next[cpuex_pkg::FL_N] = 1'b0;
            cyc_next = cpuex_pkg::CYC_8;
        end else if (nib == cpuex_pkg::NB_STA || nib == cpuex_pkg::NB_LDA) begin
            if (op_reg[3]) begin
                acc_next = mem_rdata;
            end else begin
                ex_we    = 1'b1;
                ex_addr  = paddr[MEM_ADDR_BITS-1:0];
                ex_wdata = acc_reg;
            end
            if (pr == cpuex_pkg::RP_HL) begin
                hl_next = hl_reg + 16'd1;
            end else if (pr == cpuex_pkg::RP_SP) begin
                hl_next = hl_reg - 16'd1;
            end
            cyc_next = cpuex_pkg::CYC_8;
        end else begin
            case (op_reg)
                cpuex_pkg::OP_RLCA: begin
                    acc_next   = {acc_reg[6:0], acc_reg[7]};
                    flags_next = {3'b000, acc_reg[7]};
                end
                cpuex_pkg::OP_RRCA: begin
                    acc_next   = {acc_reg[0], acc_reg[7:1]};
                    flags_next = {3'b000, acc_reg[0]};
                end
                cpuex_pkg::OP_RLA: begin
                    acc_next   = {acc_reg[6:0], flags_reg[cpuex_pkg::FL_C]};
                    flags_next = {3'b000, acc_reg[7]};
                end
                cpuex_pkg::OP_RRA: begin
                    acc_next   = {flags_reg[cpuex_pkg::FL_C], acc_reg[7:1]};
                    flags_next = {3'b000, acc_reg[0]};
                end
                cpuex_pkg::OP_DAA: begin
                    if (flags_reg[cpuex_pkg::FL_N]) begin
                        daa_s = acc_reg
                              - (flags_reg[cpuex_pkg::FL_H] ? 8'h06 : 8'h00)
                              - (flags_reg[cpuex_pkg::FL_C] ? 8'h60 : 8'h00);
                    end else begin
                        daa_t = {1'b0, acc_reg};
                        if (flags_reg[cpuex_pkg::FL_H] || acc_reg[3:0] > 4'd9) begin
                            daa_t = daa_t + 9'h006;
                        end
                        if (flags_reg[cpuex_pkg::FL_C] || daa_t > 9'h09F) begin
                            daa_t = daa_t + 9'h060;
                        end
                        daa_s = daa_t[7:0];
                    end
                    acc_next = daa_s;
                    flags_next[cpuex_pkg::FL_H] = 1'b0;
                    flags_next[cpuex_pkg::FL_Z] = (daa_s == 8'd0);
                    flags_next[cpuex_pkg::FL_C] = flags_reg[cpuex_pkg::FL_C] | daa_t[8];
                end
                cpuex_pkg::OP_CPL: begin
                    acc_next = ~acc_reg;
                    flags_next[cpuex_pkg::FL_N] = 1'b1;
                    flags_next[cpuex_pkg::FL_H] = 1'b1;
                end
                cpuex_pkg::OP_SCF: begin
                    flags_next[cpuex_pkg::FL_C] = 1'b1;
                    flags_next[cpuex_pkg::FL_N] = 1'b0;
                    flags_next[cpuex_pkg::FL_H] = 1'b0;
                end
                default: begin
                    flags_next[cpuex_pkg::FL_C] = !flags_reg[cpuex_pkg::FL_C];
                    flags_next[cpuex_pkg::FL_N] = 1'b0;
                    flags_next[cpuex_pkg::FL_H] = 1'b0;
                end
            endcase
            cyc_next = cpuex_pkg::CYC_4;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            flags_reg   <= '0;
            bc_reg      <= '0;
            de_reg      <= '0;
            hl_reg      <= '0;
            sp_reg      <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (s_xfer) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    acc_reg     <= acc_next;
                    flags_reg   <= flags_next;
                    bc_reg      <= bc_next;
                    de_reg      <= de_next;
                    hl_reg      <= hl_next;
                    sp_reg      <= sp_next;
                    pc_reg      <= pc_next;
                    stopped_reg <= stopped_next;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg <= s_opcode;
            n1_reg <= s_imm_first;
            n2_reg <= s_imm_second;
        end
        if (state_reg == ST_EXEC) begin
            cyc_reg <= cyc_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_acc_out     = acc_reg;
    assign m_flags_out   = flags_reg;
    assign m_bc_out      = bc_reg;
    assign m_de_out      = de_reg;
    assign m_hl_out      = hl_reg;
    assign m_sp_out      = sp_reg;
    assign m_pc_out      = pc_reg;
    assign m_stopped_out = stopped_reg;
    assign m_cycles_out  = cyc_reg;

    `CHK_RUN(a_exec_no_result, (state_reg == ST_EXEC) |-> !m_valid_reg, "result pending during execute")
    `CHK_RUN(a_xfer_to_exec, s_xfer |=> (state_reg == ST_EXEC), "accepted item not executed")
    `CHK_RUN(a_exec_gives_result, (state_reg == ST_EXEC) |=> m_valid_reg, "execute without result")
    `CHK_RUN(a_stop_sticky, ($past(stopped_reg) && $past(aresetn)) |-> stopped_reg, "stop flag dropped")
    `CHK_ALL(a_reset_clears, !aresetn |=> (!m_valid_reg && state_reg == ST_IDLE), "reset not clean")

endmodule

`default_nettype wire

// ===== rtl/cpuex_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpuex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire
